>>> rtl/core/dep_pkg.sv
// dep_pkg: shared types, operation and status codes for the double-ended
// priority queue. No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dep_pkg;

    // default number of slots in the table
    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_HIGH = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_LOW  = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK_HIGH   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_LOW    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] item_value;
        logic [PRIO_W-1:0]         item_priority;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [STATUS_W-1:0]       status;
        logic [OCC_W-1:0]          occupancy;
    } rsp_t;

    // one table slot as held in the memory
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         priority_val;
    } slot_t;

endpackage

>>> rtl/core/double_ended_priority_queue.sv
// double_ended_priority_queue: top level, output register around the
// sequencer and slot memory. Depends on dep_pkg, dep_ctrl and dep_slot_ram.
`timescale 1ns / 1ps

// A table of DEPTH slots, each a signed value with an unsigned priority.
// An item is taken when start is high and busy is low; busy stays high
// until the item is finished. Each item gives exactly one result, shown on
// rsp for the single cycle in which done is high, in the cycle after the item
// finishes; the receiver cannot hold it off, so it must take it then.
// Per item: an insert into a full table, a remove or peek on an empty
// table and an unused operation code finish in the accept cycle.
// Other inserts walk the valid bits one slot per cycle, ending at the
// lowest free slot. Remove and peek read every slot from the memory, one
// read port access per cycle, compare each slot read in slot order, and
// then pass through a finish state. Result is registered, so a new item
// may be accepted while done is high. Ties go to the lowest slot;
// occupancy is the entry count after the item, modulo 32.
module double_ended_priority_queue #(
    parameter int DEPTH = dep_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  dep_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output dep_pkg::rsp_t rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    dep_pkg::slot_t wr_data;
    logic           rd_en;
    logic [IW-1:0]  rd_addr;
    dep_pkg::slot_t rd_data;

    // result from the sequencer, valid for one cycle
    logic           res_vld;
    dep_pkg::rsp_t  res;

    logic           done_reg;
    dep_pkg::rsp_t  rsp_reg;

    dep_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .res_vld (res_vld),
        .res     (res),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // value and priority storage; valid bits live in the sequencer
    dep_slot_ram #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register: strobe cleared by reset, payload loaded on a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_vld)
        begin
            rsp_reg <= res;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> rtl/core/dep_slot_ram.sv
// dep_slot_ram: slot storage, one write port and one read port with a
// registered read. Depends on dep_pkg for the slot type.
`timescale 1ns / 1ps

module dep_slot_ram #(
    parameter int DEPTH = dep_pkg::DEPTH_DEFAULT,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic           clk,
    input  logic           wr_en,
    input  logic [IW-1:0]  wr_addr,
    input  dep_pkg::slot_t wr_data,
    input  logic           rd_en,
    input  logic [IW-1:0]  rd_addr,
    output dep_pkg::slot_t rd_data
);

    dep_pkg::slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/dep_ctrl.sv
// dep_ctrl: command sequencer, valid bits, entry count and the slot scan.
// Depends on dep_pkg; drives the ports of dep_slot_ram.
`timescale 1ns / 1ps

module dep_ctrl #(
    parameter int DEPTH = dep_pkg::DEPTH_DEFAULT,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  dep_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           res_vld,
    output dep_pkg::rsp_t  res,
    output logic           wr_en,
    output logic [IW-1:0]  wr_addr,
    output dep_pkg::slot_t wr_data,
    output logic           rd_en,
    output logic [IW-1:0]  rd_addr,
    input  dep_pkg::slot_t rd_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FREE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [1:0]                        state_reg, state_next;
    logic [DEPTH-1:0]                  valid_reg, valid_next;
    logic [CW-1:0]                     cnt_reg, cnt_next;
    logic [IW-1:0]                     idx_reg, idx_next;
    logic                              pipe_vld_reg, pipe_vld_next;
    logic                              pipe_last_reg, pipe_last_next;
    logic [IW-1:0]                     pipe_idx_reg, pipe_idx_next;
    logic                              found_reg, found_next;
    logic [IW-1:0]                     best_idx_reg, best_idx_next;
    logic [dep_pkg::PRIO_W-1:0]        best_prio_reg, best_prio_next;
    logic signed [dep_pkg::VALUE_W-1:0] best_value_reg, best_value_next;
    dep_pkg::cmd_t                     cmd_reg, cmd_next;

    logic want_high;
    logic removes;
    logic better;

    assign want_high = (cmd_reg.operation == dep_pkg::OP_REMOVE_HIGH)
                    || (cmd_reg.operation == dep_pkg::OP_PEEK_HIGH);
    assign removes   = (cmd_reg.operation == dep_pkg::OP_REMOVE_HIGH)
                    || (cmd_reg.operation == dep_pkg::OP_REMOVE_LOW);

    // strict compare keeps the earlier slot on a tie
    assign better = !found_reg
                 || (want_high ? (rd_data.priority_val > best_prio_reg)
                               : (rd_data.priority_val < best_prio_reg));

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pipe_vld_next   = 1'b0;
        pipe_last_next  = pipe_last_reg;
        pipe_idx_next   = pipe_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_value_next = best_value_reg;
        cmd_next        = cmd_reg;

        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '{value: cmd_reg.item_value, priority_val: cmd_reg.item_priority};
        rd_en   = 1'b0;
        rd_addr = idx_reg;

        res_vld          = 1'b0;
        res.result_value = '0;
        res.status       = dep_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    unique case (cmd.operation)
                        dep_pkg::OP_INSERT:
                        begin
                            if (cnt_reg == FULL_CNT)
                            begin
                                res_vld    = 1'b1;
                                res.status = dep_pkg::ST_FULL;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_FREE;
                            end
                        end
                        dep_pkg::OP_REMOVE_HIGH, dep_pkg::OP_REMOVE_LOW,
                        dep_pkg::OP_PEEK_HIGH, dep_pkg::OP_PEEK_LOW:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_vld    = 1'b1;
                                res.status = dep_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // first read goes out now, slot 0
                                rd_en          = 1'b1;
                                rd_addr        = '0;
                                pipe_vld_next  = 1'b1;
                                pipe_idx_next  = '0;
                                pipe_last_next = (LAST_IDX == '0);
                                idx_next       = IW'(1);
                                found_next     = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_vld = 1'b1;
                        end
                    endcase
                end
            end
            S_FREE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    wr_en               = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    cnt_next            = cnt_reg + CW'(1);
                    res_vld             = 1'b1;
                    state_next          = S_IDLE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_vld    = 1'b1;
                    res.status = dep_pkg::ST_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_SCAN:
            begin
                if (pipe_vld_reg && valid_reg[pipe_idx_reg] && better)
                begin
                    found_next      = 1'b1;
                    best_idx_next   = pipe_idx_reg;
                    best_prio_next  = rd_data.priority_val;
                    best_value_next = rd_data.value;
                end
                if (pipe_last_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = idx_reg;
                    pipe_vld_next  = 1'b1;
                    pipe_idx_next  = idx_reg;
                    pipe_last_next = (idx_reg == LAST_IDX);
                    idx_next       = idx_reg + IW'(1);
                end
            end
            S_DONE:
            begin
                res_vld    = 1'b1;
                state_next = S_IDLE;
                if (!found_reg)
                begin
                    res.status = dep_pkg::ST_EMPTY;
                end
                else
                begin
                    res.result_value = best_value_reg;
                    if (removes)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                        cnt_next                 = cnt_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // occupancy after the operation, modulo the port width
        res.occupancy = dep_pkg::OCC_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            pipe_last_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            pipe_vld_reg  <= pipe_vld_next;
            pipe_last_reg <= pipe_last_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pipe_idx_reg   <= pipe_idx_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_value_reg <= best_value_next;
        cmd_reg        <= cmd_next;
    end

    // count tracks the valid bits exactly
    a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(cnt_reg))
        else $error("entry count out of step with valid bits");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("entry count above table depth");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld && (res.status == dep_pkg::ST_FULL)) |-> (cnt_reg == FULL_CNT))
        else $error("full reported with a free slot");

    a_scan_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> (valid_reg == $past(valid_reg)))
        else $error("valid bits changed during scan");

endmodule
